@@ design/sue_pkg.sv @@
`timescale 1ns / 1ps
package sue_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_e;

  // Control of the shared min-search unit
  typedef struct packed {
    logic init;        // forget the previous minimum, start a new set
    logic clear_pass;  // drop the running candidate at the end of a pass
    logic sample;      // read data is valid, compare it
    logic commit;      // take the candidate as the new lower bound
  } sel_ctrl_t;

  // Signed order: flip the sign bits, compare unsigned
  function automatic logic less_signed(input logic [VAL_W-1:0] a,
                                       input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] fa;
    logic [VAL_W-1:0] fb;
    fa = {~a[VAL_W-1], a[VAL_W-2:0]};
    fb = {~b[VAL_W-1], b[VAL_W-2:0]};
    return fa < fb;
  endfunction

endpackage

@@ design/sue_ram.sv @@
`timescale 1ns / 1ps
module sue_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/sue_min_unit.sv @@
`timescale 1ns / 1ps
module sue_min_unit
  import sue_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sel_ctrl_t        ctrl_i,
  input  logic [VAL_W-1:0] data_i,
  output logic             found_o,
  output logic [VAL_W-1:0] best_o
);

  logic             found_q, found_d;
  logic             have_prev_q, have_prev_d;
  logic [VAL_W-1:0] best_q, best_d;
  logic [VAL_W-1:0] prev_q, prev_d;
  logic             above_prev;
  logic             below_best;

  // Candidate must lie strictly above the last value taken and below the running best
  assign above_prev = !have_prev_q || less_signed(prev_q, data_i);
  assign below_best = !found_q || less_signed(data_i, best_q);

  always_comb begin
    found_d     = found_q;
    have_prev_d = have_prev_q;
    best_d      = best_q;
    prev_d      = prev_q;
    if (ctrl_i.sample && above_prev && below_best) begin
      found_d = 1'b1;
      best_d  = data_i;
    end
    if (ctrl_i.commit) begin
      have_prev_d = 1'b1;
      prev_d      = best_q;
    end
    if (ctrl_i.clear_pass) begin
      found_d = 1'b0;
    end
    if (ctrl_i.init) begin
      found_d     = 1'b0;
      have_prev_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      found_q     <= found_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    prev_q <= prev_d;
  end

  assign found_o = found_q;
  assign best_o  = best_q;

endmodule

@@ design/sort_unique_engine_top.sv @@
// Load: one request per cycle while no set is being processed.
// Set of n stored requests with u distinct values: u+1 passes of the shared min-search
//   unit over all n entries. Emit: each result steps through EMIT_RD, EMIT_LD and
//   EMIT_HOLD, which waits out any output stall; inputs stall until the last is taken.
// Reset (rst_ni, async, active low) empties the store, clears overflow and all outputs
//   except the value; store contents need no clearing: only entries below fill are read.
`timescale 1ns / 1ps
module sort_unique_engine_top
  import sue_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [VAL_W-1:0]   item_value_i,
  input  logic                      set_end_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VAL_W-1:0]   unique_value_o,
  output logic [COUNT_W-1:0]        unique_count_o,
  output logic                      dropped_items_o,
  output logic                      run_end_o
);

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;       // stored requests of the open set
  logic             ovf_q, ovf_d;         // a request of the open set was dropped
  logic [CNT_W-1:0] scan_idx_q, scan_idx_d;
  logic             rd_vld_q, rd_vld_d;   // entry RAM read data valid this cycle
  logic [CNT_W-1:0] uniq_q, uniq_d;       // distinct values found so far
  logic [CNT_W-1:0] emit_idx_q, emit_idx_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;
  logic             out_last_q, out_last_d;

  logic             accept;
  logic             ent_we;
  logic [VAL_W-1:0] ent_rdata;
  logic             uq_we;
  logic [VAL_W-1:0] uq_rdata;
  sel_ctrl_t        sel_ctrl;
  logic             sel_found;
  logic [VAL_W-1:0] sel_best;
  logic             pass_end;

  assign accept   = in_valid_i && (state_q == ST_LOAD);
  assign ent_we   = accept && (fill_q < CNT_W'(MAX_ENTRIES));
  assign pass_end = (state_q == ST_SCAN) && (scan_idx_q == fill_q) && !rd_vld_q;
  assign uq_we    = pass_end && sel_found;

  // Raw set storage, written in arrival order
  sue_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (item_value_i),
    .raddr_i (scan_idx_q[AW-1:0]),
    .rdata_o (ent_rdata)
  );

  // Distinct values, written in ascending order as each pass finishes
  sue_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_uniq_ram (
    .clk_i   (clk_i),
    .we_i    (uq_we),
    .waddr_i (uniq_q[AW-1:0]),
    .wdata_i (sel_best),
    .raddr_i (emit_idx_q[AW-1:0]),
    .rdata_o (uq_rdata)
  );

  // Each pass finds the smallest stored value above the last one taken;
  // equal values are never above it, which removes the duplicates.
  sue_min_unit u_min_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sel_ctrl),
    .data_i  (ent_rdata),
    .found_o (sel_found),
    .best_o  (sel_best)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    scan_idx_d  = scan_idx_q;
    uniq_d      = uniq_q;
    emit_idx_d  = emit_idx_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    rd_vld_d    = 1'b0;
    sel_ctrl    = '0;

    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (ent_we) begin
            fill_d = fill_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (set_end_i) begin
            // start the first pass with no lower bound
            state_d       = ST_SCAN;
            scan_idx_d    = '0;
            uniq_d        = '0;
            sel_ctrl.init = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        sel_ctrl.sample = rd_vld_q;
        if (scan_idx_q != fill_q) begin
          rd_vld_d   = 1'b1;
          scan_idx_d = scan_idx_q + 1'b1;
        end else if (pass_end) begin
          if (sel_found) begin
            // record the value, raise the bound, run another pass
            sel_ctrl.commit     = 1'b1;
            sel_ctrl.clear_pass = 1'b1;
            uniq_d              = uniq_q + 1'b1;
            scan_idx_d          = '0;
          end else begin
            state_d    = ST_EMIT_RD;
            emit_idx_d = '0;
          end
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_valid_d = 1'b1;
        out_value_d = uq_rdata;
        out_last_d  = (emit_idx_q + 1'b1) == uniq_q;
        state_d     = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_LOAD;
            fill_d  = '0;
            ovf_d   = 1'b0;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
            state_d    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      uniq_q      <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      scan_idx_q  <= scan_idx_d;
      rd_vld_q    <= rd_vld_d;
      uniq_q      <= uniq_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

  assign in_stall_o      = (state_q != ST_LOAD);
  assign out_valid_o     = out_valid_q;
  assign unique_value_o  = out_value_q;
  assign unique_count_o  = COUNT_W'(uniq_q);
  assign dropped_items_o = ovf_q;
  assign run_end_o       = out_last_q;

  // No new request is taken while a result is pending
  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while a result is pending");

  // The store never holds more than its capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_ENTRIES))
    else $error("fill count beyond capacity");

  // Distinct values never outnumber stored entries while a set is processed;
  // the count of the previous set is held during load
  a_uniq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (uniq_q <= fill_q))
    else $error("distinct count beyond fill count");

  // Every emitted result reports a nonempty set
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (unique_count_o != '0))
    else $error("result with zero distinct count");

endmodule

@@ test/tb_sort_unique_engine_top.sv @@
`timescale 1ns / 1ps
module tb_sort_unique_engine_top;
  import sue_pkg::*;

  localparam int unsigned MAX_ENTRIES   = 64;
  localparam int unsigned ITEM_TARGET   = 350;
  // Worst set: 65 min-search passes over 64 entries, plus 64 results under long
  // output stalls. A few of those plus all sender gaps stay far below this.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 50;

  // Value mixes for the random sets
  typedef enum int {
    VALS_FULL,    // any 32-bit pattern
    VALS_NARROW,  // -4..4, many duplicates
    VALS_EDGE,    // around the signed extremes and zero
    VALS_MIXED    // one of the above, chosen per request
  } value_mix_e;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [COUNT_W-1:0]      count;
    logic                    dropped;
    logic                    last;
  } unique_result_t;

  // Tracks the open set, predicts its sorted distinct values when it closes,
  // and checks the results against them in order.
  class distinct_value_board;
    logic signed [VAL_W-1:0] set_values[MAX_ENTRIES];
    int unsigned             set_fill;
    bit                      set_overflow;
    unique_result_t          pending_uniques[$];
    int                      errors;

    function new();
      set_fill     = 0;
      set_overflow = 0;
      errors       = 0;
    endfunction

    function int pending();
      return pending_uniques.size();
    endfunction

    function void note_request(logic signed [VAL_W-1:0] value, logic last);
      logic signed [VAL_W-1:0] ordered[MAX_ENTRIES];
      logic signed [VAL_W-1:0] held;
      unique_result_t          res;
      int                      j;
      int                      distinct;
      if (set_fill < MAX_ENTRIES) begin
        set_values[set_fill] = value;
        set_fill++;
      end else begin
        set_overflow = 1'b1;
      end
      if (!last) return;
      // insertion sort, true signed order
      for (int i = 0; i < set_fill; i++) begin
        held = set_values[i];
        j = i;
        while (j > 0 && held < ordered[j-1]) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = held;
      end
      distinct = 0;
      for (int i = 0; i < set_fill; i++) begin
        if (i == 0 || ordered[i] != ordered[i-1]) begin
          ordered[distinct] = ordered[i];
          distinct++;
        end
      end
      for (int k = 0; k < distinct; k++) begin
        res.value   = ordered[k];
        res.count   = COUNT_W'(distinct);
        res.dropped = set_overflow;
        res.last    = (k == distinct - 1);
        pending_uniques.push_back(res);
      end
      set_fill     = 0;
      set_overflow = 1'b0;
    endfunction

    function void compare_field(string name, logic signed [VAL_W:0] exp,
                                logic signed [VAL_W:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic signed [VAL_W-1:0] value, logic [COUNT_W-1:0] count,
                               logic dropped, logic last);
      unique_result_t res;
      if (pending_uniques.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d count %0d",
                 $time, value, count);
        errors++;
        return;
      end
      res = pending_uniques.pop_front();
      compare_field("unique_value", res.value, value);
      compare_field("unique_count", res.count, count);
      compare_field("dropped_items", res.dropped, dropped);
      compare_field("run_end", res.last, last);
    endfunction
  endclass

  // Drive every input to a known value from time zero
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic signed [VAL_W-1:0] item_value_i = '0;
  logic                    set_end_i    = 1'b0;
  logic                    out_stall_i  = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic signed [VAL_W-1:0] unique_value_o;
  logic [COUNT_W-1:0]      unique_count_o;
  logic                    dropped_items_o;
  logic                    run_end_o;

  distinct_value_board board = new();
  int unsigned         requests_sent = 0;
  int unsigned         cycle_count   = 0;
  int                  stall_left    = 0;
  int                  quiet_left    = 0;

  sort_unique_engine_top #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .item_value_i   (item_value_i),
    .set_end_i      (set_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .unique_value_o (unique_value_o),
    .unique_count_o (unique_count_o),
    .dropped_items_o(dropped_items_o),
    .run_end_o      (run_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value(value_mix_e mix);
    value_mix_e m;
    m = mix;
    if (m == VALS_MIXED) m = value_mix_e'($urandom_range(0, 2));
    case (m)
      VALS_NARROW: return $urandom_range(0, 8) - 4;
      VALS_EDGE: begin
        case ($urandom_range(0, 6))
          0: return 32'sh8000_0000;
          1: return 32'sh8000_0001;
          2: return 32'sh7fff_ffff;
          3: return 32'sh7fff_fffe;
          4: return -32'sd1;
          5: return 32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Present one request at the falling edge; hold it until a rising edge
  // sees no stall, then note it as accepted.
  task automatic send_request(input logic signed [VAL_W-1:0] value, input logic last);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    item_value_i <= value;
    set_end_i    <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(value, last);
    requests_sent++;
  endtask

  // Drop valid for a number of cycles; scramble the idle payload meanwhile
  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i   <= 1'b0;
      item_value_i <= $urandom;
      set_end_i    <= $urandom_range(0, 1);
    end
  endtask

  // Send one whole set; the last request closes it
  task automatic send_set(input int size, input value_mix_e mix, input bit no_gaps);
    for (int i = 0; i < size; i++) begin
      send_request(pick_value(mix), i == size - 1);
      if (!no_gaps) idle_sender(idle_len());
    end
  endtask

  // Hold off the sender until every predicted result has come out
  task automatic wait_drained();
    idle_sender(1);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, with occasional quiet stretches of no stall
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (quiet_left > 0) begin
      quiet_left--;
      out_stall_i <= 1'b0;
    end else begin
      stall_left = idle_len();
      if (stall_left == 0 && $urandom_range(0, 9) == 0) quiet_left = $urandom_range(20, 80);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Check each result taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(unique_value_o, unique_count_o, dropped_items_o, run_end_o);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int r;
    int size;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_sender(2);

    // Single request that is both first and last, most negative value
    send_request(32'sh8000_0000, 1'b1);
    // Extremes and values around zero, with repeats of both extremes and zero; close on a repeat
    send_request(32'sh7fff_ffff, 1'b0);
    send_request(32'sh8000_0000, 1'b0);
    send_request(32'sd0, 1'b0);
    send_request(-32'sd1, 1'b0);
    send_request(32'sd1, 1'b0);
    send_request(32'sd0, 1'b0);
    send_request(32'sh7fff_ffff, 1'b0);
    send_request(32'sh8000_0000, 1'b1);
    // All values equal: one result
    send_request(32'sd7, 1'b0);
    send_request(32'sd7, 1'b0);
    send_request(32'sd7, 1'b1);
    // Descending pair, largest value alone
    send_request(32'sd2, 1'b0);
    send_request(32'sd1, 1'b1);
    send_request(32'sh7fff_ffff, 1'b1);
    wait_drained();

    // Exactly full store: up to 64 distinct values, no drop
    send_set(MAX_ENTRIES, VALS_FULL, 1'b1);
    // One past full: the closing request itself is dropped
    send_set(MAX_ENTRIES + 1, VALS_MIXED, 1'b0);
    // Well past full with few distinct values
    send_set(MAX_ENTRIES + 4, VALS_NARROW, 1'b1);

    while (requests_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 80) size = $urandom_range(1, 10);
      else if (r < 95) size = $urandom_range(11, 40);
      else size = $urandom_range(60, 70);
      send_set(size, value_mix_e'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    // Drain, let the block settle, then report
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/sue_pkg.sv
design/sue_ram.sv
design/sue_min_unit.sv
design/sort_unique_engine_top.sv
test/tb_sort_unique_engine_top.sv
